// File: rtl/core/frc_pkg.sv
// Shared types and constants for the fragment reassembly slot table.
// Used by every module under rtl/core; depends on nothing.
package frc_pkg;

  // Operation codes on the input tuser
  localparam logic [1:0] OP_FRAGMENT = 2'd0;
  localparam logic [1:0] OP_ACK      = 2'd1;
  localparam logic [1:0] OP_RELEASE  = 2'd2;

  // Result status codes on the output tuser
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_OUT_ORDER = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;
  localparam logic [2:0] ST_ACK_SEEN  = 3'd6;
  localparam logic [2:0] ST_RELEASED  = 3'd7;

  // Slot modes
  localparam logic [1:0] MODE_FREE     = 2'd0;
  localparam logic [1:0] MODE_RECEIVE  = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;

  // Timeout register reset value
  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // One classified command as it travels through the queue
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [15:0] sequence_id;
    logic [7:0]  fragment_index;
    logic [7:0]  fragment_count;
    logic [9:0]  payload_length;
    logic [1:0]  release_slot;
  } frc_item_t;

  // One result item
  typedef struct packed {
    logic [2:0]  status;
    logic        send_ack;
    logic [15:0] ack_sequence_id;
    logic [7:0]  ack_fragment_index;
    logic [7:0]  ack_fragment_count;
    logic [1:0]  slot_used;
    logic [8:0]  write_offset;
    logic        message_complete;
    logic [9:0]  message_length;
  } frc_result_t;

  // Queue status seen by the back end and the front end
  typedef struct packed {
    logic valid;
    logic full;
  } frc_qstat_t;

endpackage

// File: rtl/core/fragment_reassembly_contexts_top.sv
// Top level of the fragment reassembly slot table: APB timeout register,
// front end, command queue and slot engine. Depends on frc_pkg and frc_* modules.
//
//  channel  | role   | handshake                 | payload
//  ---------+--------+---------------------------+------------------------------
//  in_      | slave  | in_tvalid / in_tready     | tuser operation, tdata header
//  out_     | master | out_tvalid / out_tready   | tuser status, tdata result
//  cfg_     | APB    | psel, penable, pready = 1 | timeout_ticks at address 0
//
// A payload fragment's result goes through these steps: it leaves the queue, the
// scan visits each slot in turn for timeout and match, then the decide step loads
// the output register, waiting while the output stalls. Ack and release results are
// loaded into the output register as they leave the queue, waiting for it too.
// Reset (rst_n low, synchronous) frees all slots and sets the timeout to 10000.
// A two-entry queue keeps taking transfers, until it is full, while the engine or the output stalls.
module fragment_reassembly_contexts_top import frc_pkg::*; #(
  parameter int SLOT_COUNT   = 4,
  parameter int BUFFER_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata, low bit up: now_ms[31:0], sequence_id[47:32], fragment_index[55:48],
  // fragment_count[63:56], payload_length[73:64], release_slot[75:74], zero fill
  input  logic [79:0] in_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata, low bit up: send_ack[0], ack_sequence_id[16:1], ack_fragment_index[24:17],
  // ack_fragment_count[32:25], slot_used[34:33], write_offset[43:35],
  // message_complete[44], message_length[54:45], zero fill
  output logic [55:0] out_tdata,
  // tuser: status[2:0]
  output logic [2:0]  out_tuser,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] timeout_r;
  logic        cfg_wr;
  frc_qstat_t  qstat;
  logic        q_push, q_pop;
  frc_item_t   push_item, head_item;
  frc_result_t res;

  // Timeout register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_r <= cfg_pwdata;
    end
  end

  frc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .qstat     (qstat),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  frc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  frc_back #(
    .SLOT_COUNT   (SLOT_COUNT),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .timeout_ticks (timeout_r),
    .qstat         (qstat),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res           (res)
  );

  // Pack the result transfer
  assign out_tuser = res.status;
  assign out_tdata = {1'b0, res.message_length, res.message_complete, res.write_offset,
                      res.slot_used, res.ack_fragment_count, res.ack_fragment_index,
                      res.ack_sequence_id, res.send_ack};

endmodule

// File: rtl/core/frc_front.sv
// Input side: unpacks stream transfers, classifies the operation and pushes
// commands into the queue. Depends on frc_pkg.
module frc_front import frc_pkg::*; (
  input  logic             in_tvalid,
  output logic             in_tready,
  // tdata, low bit up: now_ms[31:0], sequence_id[47:32], fragment_index[55:48],
  // fragment_count[63:56], payload_length[73:64], release_slot[75:74], zero fill
  input  logic [79:0]      in_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]       in_tuser,
  input  frc_qstat_t       qstat,
  output logic             q_push,
  output frc_item_t        q_item
);

  logic known_op;

  // Take a transfer whenever the queue has room
  assign in_tready = !qstat.full;

  // The unused operation code is taken and dropped: no state change, no result
  assign known_op = (in_tuser == OP_FRAGMENT) || (in_tuser == OP_ACK) ||
                    (in_tuser == OP_RELEASE);
  assign q_push   = in_tvalid && in_tready && known_op;

  // Unpack fields
  always_comb begin
    q_item.op             = in_tuser;
    q_item.now_ms         = in_tdata[31:0];
    q_item.sequence_id    = in_tdata[47:32];
    q_item.fragment_index = in_tdata[55:48];
    q_item.fragment_count = in_tdata[63:56];
    q_item.payload_length = in_tdata[73:64];
    q_item.release_slot   = in_tdata[75:74];
  end

endmodule

// File: rtl/core/frc_queue.sv
// Short command queue between the front end and the slot engine.
// Depends on frc_pkg.
module frc_queue import frc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frc_item_t   push_item,
  input  logic        pop,
  output frc_item_t   head_item,
  output frc_qstat_t  qstat
);

  frc_item_t         entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign qstat.valid = (count_r != '0);
  assign qstat.full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign head_item   = entry_r[rd_ptr_r];

  assign do_push = push && !qstat.full;
  assign do_pop  = pop && qstat.valid;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/frc_back.sv
// Slot engine: scans the slot table one slot a cycle (timeout and match),
// then decides, updates the slot and loads the output register. Depends on frc_pkg.
module frc_back import frc_pkg::*; #(
  parameter int SLOT_COUNT   = 4,
  parameter int BUFFER_BYTES = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [31:0]  timeout_ticks,
  input  frc_qstat_t   qstat,
  input  frc_item_t    q_item,
  output logic         q_pop,
  output logic         res_valid,
  input  logic         res_ready,
  output frc_result_t  res
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BYTE_W = $clog2(BUFFER_BYTES + 1);
  localparam int SUM_W  = ((BYTE_W > 10) ? BYTE_W : 10) + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  // Slot table
  logic [1:0]        mode_r  [SLOT_COUNT];
  logic [15:0]       seq_r   [SLOT_COUNT];
  logic [7:0]        total_r [SLOT_COUNT];
  logic [7:0]        next_r  [SLOT_COUNT];
  logic [31:0]       last_r  [SLOT_COUNT];
  logic [BYTE_W-1:0] bytes_r [SLOT_COUNT];

  // Sequencer and captured scan results
  logic [1:0]        state_r, state_nxt;
  frc_item_t         item_r, item_nxt;
  logic [SLOT_W-1:0] scan_r, scan_nxt;
  logic              hit_found_r, hit_found_nxt;
  logic [SLOT_W-1:0] hit_r, hit_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SLOT_W-1:0] free_r, free_nxt;
  logic [7:0]        h_total_r, h_total_nxt;
  logic [7:0]        h_next_r, h_next_nxt;
  logic [BYTE_W-1:0] h_bytes_r, h_bytes_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  frc_result_t       out_r, out_nxt;
  logic              out_free;

  // Table write controls
  logic              mode_we;
  logic [SLOT_W-1:0] mode_wa;
  logic [1:0]        mode_wd;
  logic              fld_we, last_we;
  logic [SLOT_W-1:0] fld_wa;
  logic [7:0]        w_total, w_next;
  logic [BYTE_W-1:0] w_bytes;

  // Scan and decide datapath
  logic [1:0]        cur_mode;
  logic [31:0]       cur_age;
  logic              cur_expired, cur_live;
  logic [SLOT_W-1:0] sel;
  logic [7:0]        eff_total, eff_next, next_inc;
  logic [BYTE_W-1:0] eff_bytes;
  logic [SUM_W-1:0]  byte_sum;
  logic              done;

  assign res_valid = out_valid_r;
  assign res       = out_r;
  assign out_free  = !out_valid_r || res_ready;

  // Slot under the scan pointer
  assign cur_mode    = mode_r[scan_r];
  assign cur_age     = item_r.now_ms - last_r[scan_r];
  assign cur_expired = (cur_mode == MODE_RECEIVE) && (cur_age >= timeout_ticks);
  assign cur_live    = (cur_mode == MODE_RECEIVE) && !cur_expired;

  // Effective slot view at decide: matched slot, or a freshly opened one
  assign sel       = hit_found_r ? hit_r : free_r;
  assign eff_total = hit_found_r ? h_total_r : item_r.fragment_count;
  assign eff_next  = hit_found_r ? h_next_r : 8'd0;
  assign eff_bytes = hit_found_r ? h_bytes_r : '0;
  assign byte_sum  = SUM_W'(eff_bytes) + SUM_W'(item_r.payload_length);
  assign next_inc  = eff_next + 8'd1;
  assign done      = (next_inc == eff_total);

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    scan_nxt       = scan_r;
    hit_found_nxt  = hit_found_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    h_total_nxt    = h_total_r;
    h_next_nxt     = h_next_r;
    h_bytes_nxt    = h_bytes_r;
    out_valid_nxt  = out_valid_r && !res_ready;
    out_nxt        = out_r;
    q_pop          = 1'b0;
    mode_we        = 1'b0;
    mode_wa        = scan_r;
    mode_wd        = MODE_FREE;
    fld_we         = 1'b0;
    last_we        = 1'b0;
    fld_wa         = sel;
    w_total        = eff_total;
    w_next         = eff_next;
    w_bytes        = eff_bytes;

    case (state_r)
      S_IDLE: begin
        if (qstat.valid) begin
          if (q_item.op == OP_FRAGMENT) begin
            // Start a scan of the slot table
            q_pop          = 1'b1;
            item_nxt       = q_item;
            scan_nxt       = '0;
            hit_found_nxt  = 1'b0;
            free_found_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end else if (out_free) begin
            // Ack seen and release finish at once
            q_pop         = 1'b1;
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            if (q_item.op == OP_ACK) begin
              out_nxt.status = ST_ACK_SEEN;
            end else begin
              out_nxt.status    = ST_RELEASED;
              out_nxt.slot_used = q_item.release_slot;
              if (32'(q_item.release_slot) < SLOT_COUNT) begin
                mode_we = 1'b1;
                mode_wa = SLOT_W'(q_item.release_slot);
                mode_wd = MODE_FREE;
              end
            end
          end
        end
      end

      S_SCAN: begin
        // Timeout, match and first free, one slot a cycle
        if (cur_expired) begin
          mode_we = 1'b1;
          mode_wa = scan_r;
          mode_wd = MODE_FREE;
        end
        if (!hit_found_r && cur_live && (seq_r[scan_r] == item_r.sequence_id)) begin
          hit_found_nxt = 1'b1;
          hit_nxt       = scan_r;
          h_total_nxt   = total_r[scan_r];
          h_next_nxt    = next_r[scan_r];
          h_bytes_nxt   = bytes_r[scan_r];
        end
        if (!free_found_r && ((cur_mode == MODE_FREE) || cur_expired)) begin
          free_found_nxt = 1'b1;
          free_nxt       = scan_r;
        end
        if (scan_r == SLOT_W'(SLOT_COUNT - 1)) begin
          state_nxt = S_DECIDE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          state_nxt     = S_IDLE;
          if (!hit_found_r && ((item_r.fragment_index != 8'd0) || !free_found_r)) begin
            out_nxt.status = ST_NO_SLOT;
          end else begin
            out_nxt.slot_used = 2'(sel);
            // Opening a slot writes its header fields
            if (!hit_found_r) begin
              fld_we  = 1'b1;
              last_we = 1'b1;
              mode_we = 1'b1;
              mode_wa = sel;
              mode_wd = MODE_RECEIVE;
            end
            if (item_r.fragment_count != eff_total) begin
              out_nxt.status = ST_MISMATCH;
            end else if (item_r.fragment_index < eff_next) begin
              // Old fragment: re-ack and refresh the arrival time
              last_we                    = 1'b1;
              out_nxt.status             = ST_DUPLICATE;
              out_nxt.send_ack           = 1'b1;
              out_nxt.ack_sequence_id    = item_r.sequence_id;
              out_nxt.ack_fragment_index = item_r.fragment_index;
              out_nxt.ack_fragment_count = item_r.fragment_count;
            end else if (item_r.fragment_index != eff_next) begin
              out_nxt.status = ST_OUT_ORDER;
            end else if (byte_sum > SUM_W'(BUFFER_BYTES)) begin
              out_nxt.status = ST_OVERFLOW;
            end else begin
              // In-order fragment that fits
              fld_we                     = 1'b1;
              last_we                    = 1'b1;
              w_next                     = next_inc;
              w_bytes                    = BYTE_W'(byte_sum);
              out_nxt.status             = ST_ACCEPTED;
              out_nxt.send_ack           = 1'b1;
              out_nxt.ack_sequence_id    = item_r.sequence_id;
              out_nxt.ack_fragment_index = item_r.fragment_index;
              out_nxt.ack_fragment_count = item_r.fragment_count;
              out_nxt.write_offset       = 9'(eff_bytes);
              if (done) begin
                mode_we                  = 1'b1;
                mode_wa                  = sel;
                mode_wd                  = MODE_COMPLETE;
                out_nxt.message_complete = 1'b1;
                out_nxt.message_length   = 10'(byte_sum);
              end
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        mode_r[i] <= MODE_FREE;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (mode_we) begin
        mode_r[mode_wa] <= mode_wd;
      end
    end
  end

  // Payload registers and slot fields
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    scan_r       <= scan_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_r        <= hit_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    h_total_r    <= h_total_nxt;
    h_next_r     <= h_next_nxt;
    h_bytes_r    <= h_bytes_nxt;
    out_r        <= out_nxt;
    if (fld_we) begin
      seq_r[fld_wa]   <= item_r.sequence_id;
      total_r[fld_wa] <= w_total;
      next_r[fld_wa]  <= w_next;
      bytes_r[fld_wa] <= w_bytes;
    end
    if (last_we) begin
      last_r[fld_wa] <= item_r.now_ms;
    end
  end

endmodule
